@@ hdl/directory_name_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// Directory name table assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIRECTORY_NAME_TABLE_TOP_MACROS_SVH
`define DIRECTORY_NAME_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define DNT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("directory table check failed");

// next-cycle implication
`define DNT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("directory table check failed");

`endif

@@ hdl/dnt_pkg.sv @@
// ----------------------------------------------------------------------------
// Directory name table package
// Sizes, codes, entry layout and name normalization shared by the block.
// ----------------------------------------------------------------------------
package dnt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int NAME_BYTES  = 8;
    localparam int SECTOR_BITS = 16;

    localparam int NAME_W   = 8 * NAME_BYTES;
    localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int ACTIVE_W = 5;
    localparam int FNAME_W  = 64;
    localparam int FSECT_W  = 16;
    localparam int FIDX_W   = 4;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic [NAME_W-1:0]      name;
        logic [SECTOR_BITS-1:0] sector;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
        entry_t           wdata;
    } mem_req_t;

    function automatic logic [NAME_W-1:0] normalize_name(input logic [FNAME_W-1:0] raw);
        logic [NAME_W-1:0] out;
        logic              run;
        out = '0;
        run = 1'b1;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (raw[8*i +: 8] == 8'h00)
            begin
                run = 1'b0;
            end
            if (run)
            begin
                out[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return out;
    endfunction

endpackage

@@ hdl/dnt_ram.sv @@
// ----------------------------------------------------------------------------
// Directory entry RAM
// Single-port synchronous store of entry names and sectors, registered read.
// ----------------------------------------------------------------------------
module dnt_ram import dnt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rdata
);

    entry_t entry_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entry_mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata <= entry_mem[req.addr];
        end
    end

endmodule

@@ hdl/dnt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Directory table sequencer
// Walks the active entries through the RAM, finds match and first free slot,
// then updates the valid bits and RAM and registers the result.
// ----------------------------------------------------------------------------
module dnt_ctrl import dnt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ACTIVE_W-1:0]    active_entries,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic [FNAME_W-1:0]     file_name,
    input  logic [FSECT_W-1:0]     header_sector,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [FSECT_W-1:0]     found_sector,
    output logic [FIDX_W-1:0]      entry_index,
    output logic                   table_empty,
    output mem_req_t               mem_req,
    input  entry_t                 mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    opcode_t                op_reg;
    logic [NAME_W-1:0]      name_reg;
    logic [SECTOR_BITS-1:0] sector_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic                   cmp_vld_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [SECTOR_BITS-1:0] hit_sector_reg;
    logic                   free_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   out_valid_reg;
    status_t                status_reg;
    logic [FSECT_W-1:0]     found_reg;
    logic [FIDX_W-1:0]      index_reg;
    logic                   empty_reg;

    logic [CNT_W-1:0]       cnt_clamp;
    logic                   fin_go;
    logic                   do_add;
    logic                   do_remove;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [TABLE_DEPTH-1:0] use_mask;
    status_t                res_status;
    logic [FSECT_W-1:0]     res_found;
    logic [FIDX_W-1:0]      res_index;

    assign cnt_clamp = (32'(active_entries) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                                 : CNT_W'(active_entries);
    assign fin_go    = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign do_add    = (op_reg == OP_ADD) && !hit_reg && free_reg;
    assign do_remove = (op_reg == OP_REMOVE) && hit_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (do_add)
        begin
            valid_next[free_idx_reg] = 1'b1;
        end
        if (do_remove)
        begin
            valid_next[hit_idx_reg] = 1'b0;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            use_mask[i] = (32'(i) < 32'(cnt_reg));
        end
    end

    always_comb
    begin
        res_status = ST_MISSING;
        res_found  = '0;
        res_index  = '0;
        case (op_reg)
            OP_FIND:
            begin
                if (hit_reg)
                begin
                    res_status = ST_OK;
                    res_found  = FSECT_W'(hit_sector_reg);
                    res_index  = FIDX_W'(hit_idx_reg);
                end
            end
            OP_ADD:
            begin
                if (hit_reg)
                begin
                    res_status = ST_PRESENT;
                end
                else if (free_reg)
                begin
                    res_status = ST_OK;
                    res_index  = FIDX_W'(free_idx_reg);
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (hit_reg)
                begin
                    res_status = ST_OK;
                    res_index  = FIDX_W'(hit_idx_reg);
                end
            end
            default:
            begin
                res_status = ST_MISSING;
            end
        endcase
    end

    always_comb
    begin
        mem_req.rd_en        = (state_reg == S_SCAN);
        mem_req.wr_en        = fin_go && do_add;
        mem_req.addr         = (state_reg == S_FINISH) ? free_idx_reg : idx_reg[IDX_W-1:0];
        mem_req.wdata.name   = name_reg;
        mem_req.wdata.sector = sector_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_FIND;
            name_reg       <= '0;
            sector_reg     <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_sector_reg <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            found_reg      <= '0;
            index_reg      <= '0;
            empty_reg      <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= (state_reg == S_SCAN);
            cmp_idx_reg <= idx_reg[IDX_W-1:0];

            if (cmp_vld_reg)
            begin
                if (valid_reg[cmp_idx_reg] && (mem_rdata.name == name_reg) && !hit_reg)
                begin
                    hit_reg        <= 1'b1;
                    hit_idx_reg    <= cmp_idx_reg;
                    hit_sector_reg <= mem_rdata.sector;
                end
                if (!valid_reg[cmp_idx_reg] && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= cmp_idx_reg;
                end
            end

            if (out_valid_reg && out_ready && !fin_go)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg     <= opcode_t'(opcode);
                        name_reg   <= normalize_name(file_name);
                        sector_reg <= SECTOR_BITS'(header_sector);
                        cnt_reg    <= cnt_clamp;
                        idx_reg    <= '0;
                        hit_reg    <= 1'b0;
                        free_reg   <= 1'b0;
                        state_reg  <= (cnt_clamp == '0) ? S_FINISH : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if ((idx_reg + CNT_W'(1)) == cnt_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (fin_go)
                    begin
                        valid_reg     <= valid_next;
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status;
                        found_reg     <= res_found;
                        index_reg     <= res_index;
                        empty_reg     <= ~|(valid_next & use_mask);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_sector = found_reg;
    assign entry_index  = index_reg;
    assign table_empty  = empty_reg;

endmodule

@@ hdl/directory_name_table_top.sv @@
// Sequence: an accepted transaction walks n = active entries (clamped to the table
// depth) through S_SCAN and S_DRAIN to S_FINISH, or goes straight to S_FINISH when n is
// zero; S_FINISH registers the result once any pending result is taken. The walk reads
// one RAM entry per cycle; a pending result does not block the next walk.
// Reset: valid bits cleared at once, active_entries returns to 16, no RAM sweep.
// ----------------------------------------------------------------------------
// Directory name table top level
// Find, add and remove of named directory entries over a fixed entry table.
// ----------------------------------------------------------------------------
module directory_name_table_top import dnt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [ACTIVE_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [FNAME_W-1:0]  file_name,
    input  logic [FSECT_W-1:0]  header_sector,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [FSECT_W-1:0]  found_sector,
    output logic [FIDX_W-1:0]   entry_index,
    output logic                table_empty
);

    logic [ACTIVE_W-1:0] active_reg;
    mem_req_t            mem_req;
    entry_t              mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_data;
        end
    end

    dnt_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .active_entries (active_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .file_name      (file_name),
        .header_sector  (header_sector),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_sector   (found_sector),
        .entry_index    (entry_index),
        .table_empty    (table_empty),
        .mem_req        (mem_req),
        .mem_rdata      (mem_rdata)
    );

    dnt_ram u_ram
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

@@ hdl/dnt_checker.sv @@
// ----------------------------------------------------------------------------
// Directory name table port checker
// Port-level properties of the table, bound to the top level.
// ----------------------------------------------------------------------------
`include "directory_name_table_top_macros.svh"

module dnt_checker import dnt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [1:0]          status,
    input logic [FSECT_W-1:0]  found_sector,
    input logic [FIDX_W-1:0]   entry_index,
    input logic                table_empty
);

    logic [FSECT_W+FIDX_W+2:0] out_bits;

    assign out_bits = {status, found_sector, entry_index, table_empty};

    `DNT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bits))
    `DNT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `DNT_ASSERT_IMP(a_fail_index_zero, out_valid && (status != ST_OK), entry_index == '0)
    `DNT_ASSERT_IMP(a_fail_sector_zero, out_valid && (status != ST_OK), found_sector == '0)

endmodule

bind directory_name_table_top dnt_checker u_dnt_checker (.*);
